>>> design/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbfu assertion failed");

// next-cycle implication, checked out of reset
`define SBFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbfu assertion failed");

`endif

>>> design/sbfu_pkg.sv
// package: types, constants and helpers of the strided bit field unpacker
`default_nettype none

package sbfu_pkg;

  // fixed word geometry
  localparam int WordBits   = 32;
  localparam int ResBits    = WordBits - 2;          // leftover bits never exceed 30
  localparam int AccBits    = ResBits + WordBits;    // leftover plus one fresh word
  localparam int AvailBits  = 6;                     // holds 0..62
  localparam int MaxFields  = 32;                    // fields per word at most
  localparam int FieldBits  = 31;
  localparam int CountBits  = 16;
  localparam int StrideBits = 11;
  localparam int WidthBits  = 5;
  localparam int OutIdxBits = 16;
  localparam int QueueDepth = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIELD_WIDTH = 2'd0,
    CFG_VALUE_COUNT = 2'd1,
    CFG_ROW_STRIDE  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam logic [WidthBits-1:0]  FieldWidthRst = 5'd8;
  localparam logic [CountBits-1:0]  ValueCountRst = 16'd1;
  localparam logic [StrideBits-1:0] RowStrideRst  = 11'd1;

  // configuration seen by the back end
  typedef struct packed {
    logic [WidthBits-1:0]  field_width;
    logic [CountBits-1:0]  value_count;
    logic [StrideBits-1:0] row_stride;
  } cfg_t;

  // back end sequencer
  typedef enum logic {
    ENG_IDLE = 1'b0,
    ENG_EMIT = 1'b1
  } eng_state_t;

  // low ones for a field of w bits
  function automatic logic [FieldBits-1:0] width_mask(input logic [WidthBits-1:0] w);
    width_mask = ~({FieldBits{1'b1}} << w);
  endfunction

  // low ones for n leftover bits
  function automatic logic [ResBits-1:0] residual_mask(input logic [AvailBits-1:0] n);
    residual_mask = ~({ResBits{1'b1}} << n);
  endfunction

endpackage

`default_nettype wire

>>> design/sbfu_front.sv
// front end: configuration registers and input acceptance into the queue
`default_nettype none

module sbfu_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [sbfu_pkg::CountBits-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [sbfu_pkg::WordBits-1:0]   in_packed_word,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic [sbfu_pkg::WordBits-1:0]        q_push_data,
  output sbfu_pkg::cfg_t                       cfg
);

  logic [sbfu_pkg::WidthBits-1:0]  field_width_r;
  logic [sbfu_pkg::CountBits-1:0]  value_count_r;
  logic [sbfu_pkg::StrideBits-1:0] row_stride_r;
  logic                            cfg_wr;

  // register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= sbfu_pkg::FieldWidthRst;
      value_count_r <= sbfu_pkg::ValueCountRst;
      row_stride_r  <= sbfu_pkg::RowStrideRst;
    end else if (cfg_wr) begin
      unique case (sbfu_pkg::cfg_idx_t'(cfg_index))
        sbfu_pkg::CFG_FIELD_WIDTH: field_width_r <= cfg_data[sbfu_pkg::WidthBits-1:0];
        sbfu_pkg::CFG_VALUE_COUNT: value_count_r <= cfg_data;
        sbfu_pkg::CFG_ROW_STRIDE:  row_stride_r  <= cfg_data[sbfu_pkg::StrideBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.field_width = field_width_r;
  assign cfg.value_count = value_count_r;
  assign cfg.row_stride  = row_stride_r;

  // words go straight into the queue while it has room
  assign in_ready    = !q_full;
  assign q_push      = in_valid && in_ready;
  assign q_push_data = in_packed_word;

endmodule

`default_nettype wire

>>> design/sbfu_queue.sv
// two-entry word queue between front and back end
`default_nettype none

module sbfu_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [sbfu_pkg::WordBits-1:0] push_data,
  output logic                               full,
  output logic                               pop_valid,
  input  wire logic                          pop,
  output logic [sbfu_pkg::WordBits-1:0]      pop_data
);

  localparam int PtrBits = $clog2(sbfu_pkg::QueueDepth);
  localparam int CntBits = $clog2(sbfu_pkg::QueueDepth + 1);

  logic [sbfu_pkg::WordBits-1:0] entry_r [sbfu_pkg::QueueDepth];
  logic [PtrBits-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [CntBits-1:0]            count_r, count_nxt;
  logic                          do_pop;

  assign full      = (count_r == CntBits'(sbfu_pkg::QueueDepth));
  assign pop_valid = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrBits'(sbfu_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrBits'(sbfu_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/sbfu_back.sv
// back end: splits each word into fields, one field per cycle while the output is free
`default_nettype none

module sbfu_back #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sbfu_pkg::cfg_t                  cfg,
  input  wire logic                            q_valid,
  input  wire logic [sbfu_pkg::WordBits-1:0]   q_data,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sbfu_pkg::FieldBits-1:0]       out_field_value,
  output logic [sbfu_pkg::OutIdxBits-1:0]      out_dest_index,
  output logic                                 out_last_of_word,
  output logic                                 out_column_done
);

  localparam int IdxExtBits = (INDEX_BITS > sbfu_pkg::OutIdxBits) ? INDEX_BITS
                                                                  : sbfu_pkg::OutIdxBits;
  localparam int SumBits    = ((INDEX_BITS > sbfu_pkg::StrideBits) ? INDEX_BITS
                                                                   : sbfu_pkg::StrideBits) + 1;
  localparam int NBits      = $clog2(sbfu_pkg::MaxFields);

  sbfu_pkg::eng_state_t state_r, state_nxt;

  logic [sbfu_pkg::AccBits-1:0]    acc_r, acc_nxt;
  logic [sbfu_pkg::AvailBits-1:0]  avail_r, avail_nxt;
  logic [NBits-1:0]                n_r, n_nxt;
  logic [sbfu_pkg::CountBits-1:0]  fe_r, fe_nxt;
  logic [INDEX_BITS-1:0]           nidx_r, nidx_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [sbfu_pkg::FieldBits-1:0]  out_value_r, out_value_nxt;
  logic [sbfu_pkg::OutIdxBits-1:0] out_index_r, out_index_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_done_r, out_done_nxt;

  logic [sbfu_pkg::WidthBits-1:0]  eff_w;
  logic [sbfu_pkg::AvailBits-1:0]  pos;
  logic [sbfu_pkg::AccBits-1:0]    shifted;
  logic [sbfu_pkg::CountBits-1:0]  fe_inc;
  logic                            done;
  logic                            last;
  logic                            skip;
  logic                            out_free;
  logic [SumBits-1:0]              idx_sum;
  logic [IdxExtBits-1:0]           idx_ext;

  // field extraction datapath
  always_comb begin
    eff_w    = (cfg.field_width == '0) ? sbfu_pkg::WidthBits'(1) : cfg.field_width;
    pos      = avail_r - {1'b0, eff_w};
    shifted  = acc_r >> pos;
    fe_inc   = fe_r + 1'b1;
    done     = (fe_inc == cfg.value_count);
    last     = done || (n_r == NBits'(sbfu_pkg::MaxFields - 1)) || (pos < {1'b0, eff_w});
    skip     = (fe_r >= cfg.value_count);
    out_free = !out_valid_r || out_ready;
    idx_sum  = SumBits'(nidx_r) + SumBits'(cfg.row_stride);
    idx_ext  = IdxExtBits'(nidx_r);
  end

  // sequencer: load a word (or drop it once the column is done), then emit its fields
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    avail_nxt     = avail_r;
    n_nxt         = n_r;
    fe_nxt        = fe_r;
    nidx_nxt      = nidx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    q_pop         = 1'b0;
    unique case (state_r)
      sbfu_pkg::ENG_IDLE: begin
        q_pop = q_valid;
        if (q_valid && !skip) begin
          acc_nxt   = {acc_r[sbfu_pkg::ResBits-1:0] & sbfu_pkg::residual_mask(avail_r), q_data};
          avail_nxt = avail_r + sbfu_pkg::AvailBits'(sbfu_pkg::WordBits);
          n_nxt     = '0;
          state_nxt = sbfu_pkg::ENG_EMIT;
        end
      end
      sbfu_pkg::ENG_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = shifted[sbfu_pkg::FieldBits-1:0] & sbfu_pkg::width_mask(eff_w);
          out_index_nxt = idx_ext[sbfu_pkg::OutIdxBits-1:0];
          out_last_nxt  = last;
          out_done_nxt  = done;
          fe_nxt        = fe_inc;
          nidx_nxt      = done ? '0 : idx_sum[INDEX_BITS-1:0];
          avail_nxt     = done ? '0 : pos;
          n_nxt         = n_r + 1'b1;
          if (last) begin
            state_nxt = sbfu_pkg::ENG_IDLE;
          end
        end
      end
      default: state_nxt = sbfu_pkg::ENG_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbfu_pkg::ENG_IDLE;
      avail_r     <= '0;
      fe_r        <= '0;
      nidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avail_r     <= avail_nxt;
      fe_r        <= fe_nxt;
      nidx_r      <= nidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    n_r         <= n_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_field_value  = out_value_r;
  assign out_dest_index   = out_index_r;
  assign out_last_of_word = out_last_r;
  assign out_column_done  = out_done_r;

endmodule

`default_nettype wire

>>> design/strided_bit_field_unpacker.sv
// top level of the strided bit field unpacker
// Usage:
//   in_*  : one 32-bit packed word per transaction (valid/ready). Fields of
//           field_width bits lie back to back, msb first, and may straddle words.
//   out_* : one transaction per extracted field, with its destination index
//           (field number times row_stride), last_of_word and column_done flags.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Timing:
//   a word is queued in a two-entry queue; the back end loads it while idle
//   and then emits one field per cycle while out_ready does not stall it;
//   a word yields about 32 / field_width fields. The first field of a word
//   passes the queue entry, the back-end load and the output register in turn.
//   Words after a finished column are popped and dropped.
// Reset:
//   field_width 8, value_count 1, row_stride 1; leftover bits, field count
//   and index cleared; queue and output register empty.
// Stall:
//   a stalled out_ready holds the output register, the back end waits, and
//   in_ready drops once both queue entries hold words.
`default_nettype none
`include "assert_macros.svh"

module strided_bit_field_unpacker #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [sbfu_pkg::CountBits-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sbfu_pkg::WordBits-1:0]    in_packed_word,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sbfu_pkg::FieldBits-1:0]        out_field_value,
  output logic [sbfu_pkg::OutIdxBits-1:0]       out_dest_index,
  output logic                                  out_last_of_word,
  output logic                                  out_column_done
);

  sbfu_pkg::cfg_t                cfg;
  logic                          q_full;
  logic                          q_push;
  logic [sbfu_pkg::WordBits-1:0] q_push_data;
  logic                          q_valid;
  logic                          q_pop;
  logic [sbfu_pkg::WordBits-1:0] q_data;
  logic [sbfu_pkg::WidthBits-1:0] eff_w;

  // configuration and input acceptance
  sbfu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packed_word (in_packed_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_data    (q_push_data),
    .cfg            (cfg)
  );

  // decoupling queue
  sbfu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  // field extraction
  sbfu_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_field_value  (out_field_value),
    .out_dest_index   (out_dest_index),
    .out_last_of_word (out_last_of_word),
    .out_column_done  (out_column_done)
  );

  // effective width for checking
  assign eff_w = (cfg.field_width == '0) ? sbfu_pkg::WidthBits'(1) : cfg.field_width;

  // a column always ends its word
  `SBFU_ASSERT_NOW(a_done_ends_word, out_valid && out_column_done, out_last_of_word)
  // an emitted field never holds bits above the field width
  `SBFU_ASSERT_NOW(a_value_fits_width, out_valid,
                   (out_field_value & ~sbfu_pkg::width_mask(eff_w)) == '0)
  // after a completed column is taken, the next field starts at index zero
  `SBFU_ASSERT_NEXT(a_index_restarts, out_valid && out_ready && out_column_done,
                    !out_valid || out_dest_index == '0)

endmodule

`default_nettype wire
